/* src/tlbsa_pkg.sv */
// Shared types and constants for the two-level bitmap slot allocator.
// Used by the divider, the controller, the datapath and the top level; depends on nothing.
package tlbsa_pkg;

  localparam int IDX_W  = 12;
  localparam int DATA_W = 32;
  localparam int CFG_W  = 6;
  localparam int FUNC_W = 2;
  localparam int ST_W   = 2;

  localparam int IN_TDATA_W  = ((IDX_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((IDX_W + DATA_W + 7) / 8) * 8;
  localparam int TUSER_W     = 8;

  localparam int NUM_BUCKETS_DEF  = 64;
  localparam int MAX_SLOTS_DEF    = 64;
  localparam int ELEMENT_BITS_DEF = 32;

  localparam logic [CFG_W-1:0] BUCKET_SIZE_RST = 6'd63;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_GET   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD  = 2'd2;

  // Kind of result the controller asks the datapath to register.
  typedef enum logic [2:0] {
    RES_ALLOC = 3'd0,
    RES_GET   = 3'd1,
    RES_FREE  = 3'd2,
    RES_FULL  = 3'd3,
    RES_BAD   = 3'd4
  } res_t;

  typedef struct packed {
    logic capture;
    logic find_bkt;
    logic next_bkt;
    logic rd_row;
    logic alloc_wr;
    logic div_start;
    logic div_load;
    logic rd_elem;
    logic free_wr;
    logic out_load;
    res_t res;
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              bkt_found;
    logic              slot_found;
    logic              last_bkt;
    logic              div_done;
    logic              hit;
    logic              out_free;
  } dp_sts_t;

endpackage

/* src/tlbsa_div.sv */
// Restoring divider, one quotient bit per cycle, splits an element index
// into bucket and slot. Depends on tlbsa_pkg for the index width.
module tlbsa_div #(
  parameter int DVR_W = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tlbsa_pkg::IDX_W-1:0] dividend,
  input  logic [DVR_W-1:0]           divisor,
  output logic                       done,
  output logic [tlbsa_pkg::IDX_W-1:0] quotient,
  output logic [DVR_W-1:0]           remainder
);

  localparam int QW    = tlbsa_pkg::IDX_W;
  localparam int CNT_W = $clog2(QW + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [QW-1:0]    quo_r, quo_nxt;
  logic [DVR_W-1:0] rem_r, rem_nxt;
  logic [DVR_W-1:0] dvr_r, dvr_nxt;
  logic [DVR_W:0]   trial;
  logic             ge;

  assign trial = {rem_r, quo_r[QW-1]};
  assign ge    = (trial >= {1'b0, dvr_r});

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvr_nxt  = dvr_r;
    if (start) begin
      cnt_nxt = CNT_W'(QW);
      quo_nxt = dividend;
      rem_nxt = '0;
      dvr_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
      quo_nxt  = {quo_r[QW-2:0], ge};
      // The trial value stays below twice the divisor, so one subtract suffices.
      rem_nxt  = ge ? DVR_W'(trial - {1'b0, dvr_r}) : DVR_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvr_r <= dvr_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

/* src/tlbsa_dp.sv */
// Datapath: configuration register, bucket-full bits, slot mask memory,
// element memory, divider and output register. Depends on tlbsa_pkg and tlbsa_div.
module tlbsa_dp #(
  parameter int NUM_BUCKETS  = tlbsa_pkg::NUM_BUCKETS_DEF,
  parameter int MAX_SLOTS    = tlbsa_pkg::MAX_SLOTS_DEF,
  parameter int ELEMENT_BITS = tlbsa_pkg::ELEMENT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tlbsa_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic [tlbsa_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [tlbsa_pkg::TUSER_W-1:0]     in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tlbsa_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [tlbsa_pkg::TUSER_W-1:0]     out_tuser,
  input  tlbsa_pkg::dp_cmd_t                cmd,
  output tlbsa_pkg::dp_sts_t                sts
);

  localparam int IDX_W  = tlbsa_pkg::IDX_W;
  localparam int DATA_W = tlbsa_pkg::DATA_W;
  localparam int CFG_W  = tlbsa_pkg::CFG_W;
  localparam int ST_W   = tlbsa_pkg::ST_W;
  localparam int BKT_W  = $clog2(NUM_BUCKETS);
  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int SZ_W   = $clog2(MAX_SLOTS + 1);
  localparam int DEPTH  = NUM_BUCKETS * MAX_SLOTS;
  localparam int EA_W   = $clog2(DEPTH);
  localparam int PROD_W = BKT_W + SZ_W;
  localparam int PAD_W  = tlbsa_pkg::OUT_TDATA_W - IDX_W - DATA_W;

  // Configuration and captured item.
  logic [CFG_W-1:0]              size_r;
  logic [tlbsa_pkg::FUNC_W-1:0]  func_r;
  logic [IDX_W-1:0]              idx_r;
  logic [ELEMENT_BITS-1:0]       data_r;

  // Occupancy state. A row that was never written reads as all free.
  logic [NUM_BUCKETS-1:0]        full_r;
  logic [NUM_BUCKETS-1:0]        row_vld_r;
  logic [MAX_SLOTS-1:0]          mask_mem [NUM_BUCKETS];
  logic [MAX_SLOTS-1:0]          mask_rd_r;
  logic                          rd_vld_r;
  logic [ELEMENT_BITS-1:0]       elem_mem [DEPTH];
  logic [ELEMENT_BITS-1:0]       elem_rd_r;

  logic [BKT_W-1:0]              bkt_r;
  logic [SLOT_W-1:0]             slot_r;
  logic                          in_range_r;
  logic [PROD_W-1:0]             prod_r;

  logic                          out_tvalid_r;
  logic [ST_W-1:0]               out_status_r;
  logic [IDX_W-1:0]              out_idx_r;
  logic [DATA_W-1:0]             out_data_r;

  logic [CFG_W-1:0]              size_clip;
  logic [SZ_W-1:0]               size_eff;
  logic [MAX_SLOTS-1:0]          used;
  logic [MAX_SLOTS-1:0]          row;
  logic [MAX_SLOTS-1:0]          alloc_row;
  logic [MAX_SLOTS-1:0]          free_row;
  logic                          full_after;
  logic                          slot_found;
  logic [SLOT_W-1:0]             cand_slot;
  logic                          bkt_found;
  logic [BKT_W-1:0]              cand_bkt;
  logic [EA_W-1:0]               wr_addr;
  logic [EA_W-1:0]               rd_addr;
  logic [PROD_W:0]               idx_sum;
  logic                          out_free;
  logic                          div_done;
  logic [IDX_W-1:0]              quo;
  logic [SZ_W-1:0]               rem;

  // A size of zero acts as one, and a size above the bucket capacity is capped.
  always_comb begin
    if (size_r == '0) begin
      size_clip = CFG_W'(1);
    end else if (int'(size_r) > MAX_SLOTS) begin
      size_clip = CFG_W'(MAX_SLOTS);
    end else begin
      size_clip = size_r;
    end
    size_eff = SZ_W'(size_clip);
  end

  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      used[i] = (i < int'(size_eff));
    end
  end

  assign row = rd_vld_r ? mask_rd_r : '0;

  always_comb begin
    slot_found = 1'b0;
    cand_slot  = '0;
    for (int s = MAX_SLOTS - 1; s >= 0; s--) begin
      if (used[s] && !row[s]) begin
        slot_found = 1'b1;
        cand_slot  = SLOT_W'(s);
      end
    end
  end

  // First bucket at or after the scan pointer whose full bit is clear.
  always_comb begin
    bkt_found = 1'b0;
    cand_bkt  = '0;
    for (int i = NUM_BUCKETS - 1; i >= 0; i--) begin
      if (!full_r[i] && (i >= int'(bkt_r))) begin
        bkt_found = 1'b1;
        cand_bkt  = BKT_W'(i);
      end
    end
  end

  assign alloc_row  = row | (MAX_SLOTS'(1) << cand_slot);
  assign free_row   = row & ~(MAX_SLOTS'(1) << slot_r);
  assign full_after = ((alloc_row & used) == used);
  assign wr_addr    = EA_W'(int'(bkt_r) * MAX_SLOTS + int'(cand_slot));
  assign rd_addr    = EA_W'(int'(bkt_r) * MAX_SLOTS + int'(slot_r));
  assign idx_sum    = {1'b0, prod_r} + (PROD_W + 1)'(slot_r);
  assign out_free   = !out_tvalid_r || out_tready;

  tlbsa_div #(
    .DVR_W(SZ_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (idx_r),
    .divisor   (size_eff),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r       <= tlbsa_pkg::BUCKET_SIZE_RST;
      full_r       <= '0;
      row_vld_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
      if (cmd.alloc_wr) begin
        row_vld_r[bkt_r] <= 1'b1;
        if (full_after) begin
          full_r[bkt_r] <= 1'b1;
        end
      end else if (cmd.free_wr) begin
        full_r[bkt_r] <= 1'b0;
      end
      if (cmd.out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_tuser[tlbsa_pkg::FUNC_W-1:0];
      idx_r  <= in_tdata[IDX_W-1:0];
      data_r <= ELEMENT_BITS'(in_tdata[IDX_W+DATA_W-1:IDX_W]);
      bkt_r  <= '0;
    end else if (cmd.find_bkt) begin
      bkt_r <= cand_bkt;
    end else if (cmd.next_bkt) begin
      bkt_r <= bkt_r + BKT_W'(1);
    end else if (cmd.div_load) begin
      bkt_r <= BKT_W'(quo);
    end
    if (cmd.div_load) begin
      slot_r     <= SLOT_W'(rem);
      in_range_r <= (int'(quo) < NUM_BUCKETS);
    end else if (cmd.alloc_wr) begin
      slot_r <= cand_slot;
      prod_r <= {{SZ_W{1'b0}}, bkt_r} * {{BKT_W{1'b0}}, size_eff};
    end
    if (cmd.rd_row) begin
      rd_vld_r <= row_vld_r[bkt_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc_wr) begin
      mask_mem[bkt_r] <= alloc_row;
    end else if (cmd.free_wr) begin
      mask_mem[bkt_r] <= free_row;
    end
    if (cmd.rd_row) begin
      mask_rd_r <= mask_mem[bkt_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc_wr) begin
      elem_mem[wr_addr] <= data_r;
    end
    if (cmd.rd_elem) begin
      elem_rd_r <= elem_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_idx_r  <= '0;
      out_data_r <= '0;
      unique case (cmd.res)
        tlbsa_pkg::RES_ALLOC: begin
          out_status_r <= tlbsa_pkg::ST_OK;
          out_idx_r    <= IDX_W'(idx_sum);
        end
        tlbsa_pkg::RES_GET: begin
          out_status_r <= tlbsa_pkg::ST_OK;
          out_data_r   <= DATA_W'(elem_rd_r);
        end
        tlbsa_pkg::RES_FREE: out_status_r <= tlbsa_pkg::ST_OK;
        tlbsa_pkg::RES_FULL: out_status_r <= tlbsa_pkg::ST_FULL;
        default:             out_status_r <= tlbsa_pkg::ST_BAD;
      endcase
    end
  end

  assign sts.func       = func_r;
  assign sts.bkt_found  = bkt_found;
  assign sts.slot_found = slot_found;
  assign sts.last_bkt   = (int'(bkt_r) == NUM_BUCKETS - 1);
  assign sts.div_done   = div_done;
  assign sts.hit        = in_range_r && row[slot_r];
  assign sts.out_free   = out_free;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_data_r, out_idx_r};
  assign out_tuser  = {{(tlbsa_pkg::TUSER_W - ST_W){1'b0}}, out_status_r};

  a_no_double_wr: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.alloc_wr && cmd.free_wr))
    else $error("allocate and free write the slot masks in the same cycle");

  a_alloc_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc_wr |-> slot_found)
    else $error("allocation written without a free slot");

  a_find_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.find_bkt |=> !full_r[bkt_r])
    else $error("scan selected a bucket that is marked full");

  a_free_clears_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.free_wr |=> !full_r[$past(bkt_r)])
    else $error("free left the bucket-full bit set");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid_r || out_tready))
    else $error("result register loaded while the previous result waits");

endmodule

/* src/tlbsa_ctrl.sv */
// Controller state machine: sequences allocate scans, index division and
// mask read-modify-writes. Depends on tlbsa_pkg for the command and status structs.
module tlbsa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  tlbsa_pkg::dp_sts_t sts,
  output tlbsa_pkg::dp_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DISP  = 9'b000000010,
    S_FIND  = 9'b000000100,
    S_ARD   = 9'b000001000,
    S_ACHK  = 9'b000010000,
    S_DWAIT = 9'b000100000,
    S_GRD   = 9'b001000000,
    S_GCHK  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t            state_r, state_nxt;
  tlbsa_pkg::res_t   res_r, res_nxt;

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    cmd       = '0;
    cmd.res   = res_r;
    in_tready = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.func) inside
          tlbsa_pkg::FUNC_ALLOC: state_nxt = S_FIND;
          tlbsa_pkg::FUNC_GET, tlbsa_pkg::FUNC_FREE: begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DWAIT;
          end
          default: begin
            res_nxt   = tlbsa_pkg::RES_BAD;
            state_nxt = S_OUT;
          end
        endcase
      end
      S_FIND: begin
        if (sts.bkt_found) begin
          cmd.find_bkt = 1'b1;
          state_nxt    = S_ARD;
        end else begin
          res_nxt   = tlbsa_pkg::RES_FULL;
          state_nxt = S_OUT;
        end
      end
      S_ARD: begin
        cmd.rd_row = 1'b1;
        state_nxt  = S_ACHK;
      end
      S_ACHK: begin
        // A bucket without a free slot below the current size is skipped.
        if (sts.slot_found) begin
          cmd.alloc_wr = 1'b1;
          res_nxt      = tlbsa_pkg::RES_ALLOC;
          state_nxt    = S_OUT;
        end else if (sts.last_bkt) begin
          res_nxt   = tlbsa_pkg::RES_FULL;
          state_nxt = S_OUT;
        end else begin
          cmd.next_bkt = 1'b1;
          state_nxt    = S_FIND;
        end
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          cmd.div_load = 1'b1;
          state_nxt    = S_GRD;
        end
      end
      S_GRD: begin
        cmd.rd_row  = 1'b1;
        cmd.rd_elem = 1'b1;
        state_nxt   = S_GCHK;
      end
      S_GCHK: begin
        if (!sts.hit) begin
          res_nxt = tlbsa_pkg::RES_BAD;
        end else if (sts.func == tlbsa_pkg::FUNC_FREE) begin
          cmd.free_wr = 1'b1;
          res_nxt     = tlbsa_pkg::RES_FREE;
        end else begin
          res_nxt = tlbsa_pkg::RES_GET;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_r   <= tlbsa_pkg::RES_BAD;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

endmodule

/* src/two_level_bitmap_slot_allocator_unit.sv */
// Two-level bitmap slot allocator. One item is in work at a time. Allocate scans
// buckets from the first and skips each bucket without a free slot, returning full when
// no bucket is left; get and free wait on the 12-step index divider and the registered
// slot mask read; an unused function goes straight to a bad status.
// The next item is taken the cycle after a result is registered. Synchronous reset
// clears all occupancy at once (row valid bits, no clearing pass) and sets the
// bucket size to 63; element words are not cleared.
module two_level_bitmap_slot_allocator_unit #(
  parameter int NUM_BUCKETS  = tlbsa_pkg::NUM_BUCKETS_DEF,
  parameter int MAX_SLOTS    = tlbsa_pkg::MAX_SLOTS_DEF,
  parameter int ELEMENT_BITS = tlbsa_pkg::ELEMENT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tlbsa_pkg::CFG_W-1:0]       cfg_wdata,   // bucket_size
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tlbsa_pkg::IN_TDATA_W-1:0]  in_tdata,    // index[11:0], data_in[43:12]
  input  logic [tlbsa_pkg::TUSER_W-1:0]     in_tuser,    // func[1:0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tlbsa_pkg::OUT_TDATA_W-1:0] out_tdata,   // index_out[11:0], data_out[43:12]
  output logic [tlbsa_pkg::TUSER_W-1:0]     out_tuser    // status[1:0]
);

  tlbsa_pkg::dp_cmd_t cmd;
  tlbsa_pkg::dp_sts_t sts;

  tlbsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tlbsa_dp #(
    .NUM_BUCKETS  (NUM_BUCKETS),
    .MAX_SLOTS    (MAX_SLOTS),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
